FILE: sv/tds_pkg.sv
// ----------------------------------------------------------------------------
// tds_pkg: shared types and constants for the TDS median filter converter
// Widths, fixed-point scale factors and polynomial coefficients.
// ----------------------------------------------------------------------------
package tds_pkg;

    localparam int MEDIAN_W        = 12;
    localparam int TEMP_W          = 12;
    localparam int PPM_W           = 10;
    localparam int RING_DEPTH_DEF  = 30;
    localparam int SAMPLE_BITS_DEF = 12;

    // Voltage path: vq = m * 1600 * 65536 / (3003 * (400 + t)).
    localparam int NUM_W = 39;
    localparam int DEN_W = 23;
    localparam int REM_W = 24;
    localparam int VQ_W  = 18;
    localparam int SQ_W  = 20;
    localparam int CU_W  = 21;
    localparam int ACC_W = 40;
    localparam int IT_W  = 6;

    localparam logic [26:0]       NUM_SCALE = 27'd104857600;
    localparam logic [11:0]       DEN_SCALE = 12'd3003;
    localparam logic [12:0]       TEMP_BIAS = 13'd400;
    localparam logic [VQ_W-1:0]   VQ_CAP    = 18'd196608;
    localparam logic [ACC_W-1:0]  COEF_CU   = 40'd13342;
    localparam logic [ACC_W-1:0]  COEF_SQ   = 40'd25586;
    localparam logic [ACC_W-1:0]  COEF_V    = 40'd85739;

    // ppm = floor((acc >> 19) / 25), clamped at 1000.
    localparam int              PPM_SHIFT = 19;
    localparam logic [14:0]     X_LIMIT   = 15'd25000;
    localparam logic [15:0]     RECIP_25  = 16'd41944;
    localparam logic [PPM_W-1:0] PPM_MAX  = 10'd1000;

    typedef struct packed {
        logic                done;
        logic [MEDIAN_W-1:0] median;
    } t_ring_res;

endpackage

FILE: sv/tds_if.sv
// ----------------------------------------------------------------------------
// tds_if: request and result channels of the TDS converter
// Valid/ready channels carrying one request or one result each.
// ----------------------------------------------------------------------------
interface tds_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] adc_sample;
    logic        sample_valid;
    logic signed [11:0] water_temp_sixteenths;

    modport source (output valid, adc_sample, sample_valid, water_temp_sixteenths,
                    input ready);
    modport sink   (input valid, adc_sample, sample_valid, water_temp_sixteenths,
                    output ready);
endinterface

interface tds_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] median_raw;
    logic [9:0]  tds_ppm;

    modport source (output valid, median_raw, tds_ppm, input ready);
    modport sink   (input valid, median_raw, tds_ppm, output ready);
endinterface

FILE: sv/tds_ring.sv
// ----------------------------------------------------------------------------
// tds_ring: sample ring memory with median selection
// Stores valid samples and finds the median by a bitwise radix search.
// ----------------------------------------------------------------------------
module tds_ring #(
    parameter int RING_DEPTH  = tds_pkg::RING_DEPTH_DEF,
    parameter int SAMPLE_BITS = tds_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_store,
    input  logic [tds_pkg::MEDIAN_W-1:0]  i_sample,
    output tds_pkg::t_ring_res            o_res
);
    import tds_pkg::*;

    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int BIT_W = (SAMPLE_BITS > 1) ? $clog2(SAMPLE_BITS) : 1;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} t_state;

    logic [SAMPLE_BITS-1:0] r_ring [RING_DEPTH];
    logic [SAMPLE_BITS-1:0] r_rdata;

    t_state                 r_state;
    logic [IDX_W-1:0]       r_slot;
    logic [CNT_W-1:0]       r_fill, r_n, r_addr, r_cnt, r_k, r_k0;
    logic                   r_pv, r_second;
    logic [BIT_W-1:0]       r_bit;
    logic [SAMPLE_BITS-1:0] r_mask, r_pref, r_first;
    logic [SAMPLE_BITS-1:0] bit_sel, new_pref, sample_st;
    logic [SAMPLE_BITS:0]   pair_sum;
    logic [SAMPLE_BITS+MEDIAN_W-1:0] ext_in;
    logic [CNT_W-1:0]       fill_nx;
    logic                   match, take_zero;

    assign ext_in    = {{SAMPLE_BITS{1'b0}}, i_sample};
    assign sample_st = ext_in[SAMPLE_BITS-1:0];
    assign fill_nx   = (i_store && (r_fill < CNT_W'(RING_DEPTH))) ? r_fill + 1'b1 : r_fill;
    assign bit_sel   = SAMPLE_BITS'(1) << r_bit;
    assign match     = (((r_rdata ^ r_pref) & r_mask) == '0) && ((r_rdata & bit_sel) == '0);
    assign take_zero = r_k < r_cnt;
    assign new_pref  = take_zero ? r_pref : (r_pref | bit_sel);
    assign pair_sum  = {1'b0, r_first} + {1'b0, new_pref};

    // Ring storage: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_start && i_store) begin
            r_ring[r_slot] <= sample_st;
        end
        r_rdata <= r_ring[r_addr[IDX_W-1:0]];
    end

    function automatic logic [MEDIAN_W-1:0] to_med(input logic [SAMPLE_BITS-1:0] v);
        logic [SAMPLE_BITS+MEDIAN_W-1:0] e;
        e = {{MEDIAN_W{1'b0}}, v};
        return e[MEDIAN_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_fill      <= '0;
            r_pv        <= 1'b0;
            o_res.done  <= 1'b0;
        end else begin
            o_res.done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if (i_store) begin
                            r_slot <= (r_slot == IDX_W'(RING_DEPTH - 1)) ? '0 : r_slot + 1'b1;
                        end
                        r_fill   <= fill_nx;
                        r_n      <= fill_nx;
                        r_k      <= (fill_nx - 1'b1) >> 1;
                        r_k0     <= (fill_nx - 1'b1) >> 1;
                        r_bit    <= BIT_W'(SAMPLE_BITS - 1);
                        r_mask   <= '0;
                        r_pref   <= '0;
                        r_addr   <= '0;
                        r_cnt    <= '0;
                        r_pv     <= 1'b0;
                        r_second <= 1'b0;
                        if (fill_nx == '0) begin
                            o_res.median <= '0;
                            r_state      <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_pv <= r_addr < r_n;
                    if (r_addr < r_n) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    if (r_pv && match) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (!r_pv && (r_addr == r_n)) begin
                        // All counts for this bit are in: fix the bit.
                        r_addr <= '0;
                        r_cnt  <= '0;
                        if (r_bit != '0) begin
                            if (!take_zero) begin
                                r_k <= r_k - r_cnt;
                            end
                            r_pref <= new_pref;
                            r_mask <= r_mask | bit_sel;
                            r_bit  <= r_bit - 1'b1;
                        end else if (!r_second && !r_n[0]) begin
                            // Even count: search the upper middle value next.
                            r_first  <= new_pref;
                            r_second <= 1'b1;
                            r_k      <= r_k0 + 1'b1;
                            r_pref   <= '0;
                            r_mask   <= '0;
                            r_bit    <= BIT_W'(SAMPLE_BITS - 1);
                        end else begin
                            o_res.median <= r_second ? to_med(pair_sum[SAMPLE_BITS:1])
                                                     : to_med(new_pref);
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    o_res.done <= 1'b1;
                    r_state    <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: sv/tds_conv.sv
// ----------------------------------------------------------------------------
// tds_conv: median to compensated TDS conversion
// Serial divider for probe volts, then the cubic polynomial and clamp.
// ----------------------------------------------------------------------------
module tds_conv (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic                               i_take,
    input  logic [tds_pkg::MEDIAN_W-1:0]       i_median,
    input  logic signed [tds_pkg::TEMP_W-1:0]  i_temp,
    output logic                               o_done,
    output logic [tds_pkg::PPM_W-1:0]          o_ppm
);
    import tds_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_CAP, S_SQ, S_CU, S_T1, S_T2, S_T3, S_SCALE, S_DONE
    } t_state;

    t_state                   r_state;
    logic [NUM_W-1:0]         r_num;
    logic [DEN_W-1:0]         r_den;
    logic [REM_W-1:0]         r_rem;
    logic [IT_W-1:0]          r_it;
    logic [VQ_W-1:0]          r_vq;
    logic [SQ_W-1:0]          r_sq;
    logic [CU_W-1:0]          r_cu;
    logic signed [ACC_W-1:0]  r_acc;

    logic signed [TEMP_W:0]   denom_t;
    logic [REM_W-1:0]         rem_sh;
    logic                     ge;
    logic [2*VQ_W-1:0]        sq_prod;
    logic [SQ_W+VQ_W-1:0]     cu_prod;
    logic [ACC_W-PPM_SHIFT-2:0] x_val;
    logic [30:0]              q_prod;

    assign denom_t = $signed({i_temp[TEMP_W-1], i_temp}) + $signed(TEMP_BIAS);
    assign rem_sh  = {r_rem[REM_W-2:0], r_num[NUM_W-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign sq_prod = r_vq * r_vq;
    assign cu_prod = r_sq * {{(SQ_W-VQ_W){1'b0}}, r_vq};
    assign x_val   = r_acc[ACC_W-2:PPM_SHIFT];
    assign q_prod  = {16'b0, x_val[14:0]} * {15'b0, RECIP_25};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_num <= {{(NUM_W-MEDIAN_W){1'b0}}, i_median}
                                 * NUM_W'(NUM_SCALE);
                        r_den <= DEN_W'({12'b0, DEN_SCALE} * {12'b0, denom_t[11:0]});
                        r_rem <= '0;
                        r_it  <= '0;
                        if (denom_t <= 0) begin
                            o_ppm   <= '0;
                            o_done  <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem <= ge ? rem_sh - {1'b0, r_den} : rem_sh;
                    r_num <= {r_num[NUM_W-2:0], ge};
                    r_it  <= r_it + 1'b1;
                    if (r_it == IT_W'(NUM_W - 1)) begin
                        r_state <= S_CAP;
                    end
                end
                S_CAP: begin
                    r_vq    <= (r_num > NUM_W'(VQ_CAP)) ? VQ_CAP : r_num[VQ_W-1:0];
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_sq    <= sq_prod[2*VQ_W-1:16];
                    r_state <= S_CU;
                end
                S_CU: begin
                    r_cu    <= cu_prod[CU_W+15:16];
                    r_state <= S_T1;
                end
                S_T1: begin
                    r_acc   <= $signed(ACC_W'(r_cu) * COEF_CU);
                    r_state <= S_T2;
                end
                S_T2: begin
                    r_acc   <= r_acc - $signed(ACC_W'(r_sq) * COEF_SQ);
                    r_state <= S_T3;
                end
                S_T3: begin
                    r_acc   <= r_acc + $signed(ACC_W'(r_vq) * COEF_V);
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    if (r_acc[ACC_W-1]) begin
                        o_ppm <= '0;
                    end else if (x_val >= (ACC_W-PPM_SHIFT-1)'(X_LIMIT)) begin
                        o_ppm <= PPM_MAX;
                    end else begin
                        o_ppm <= q_prod[PPM_W+19:20];
                    end
                    o_done  <= 1'b1;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_take) begin
                        o_done  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: sv/tds_median_filter_convert_core.sv
// ----------------------------------------------------------------------------
// tds_median_filter_convert_core: running median filter and TDS conversion
// Top level joining the sample ring, the converter and the result register.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on i_req: a converter sample, its valid flag and the water
// temperature in sixteenths of a degree. A valid sample is stored in the ring.
// Every request returns exactly one result on o_res: the median of the
// stored samples and the compensated TDS value in ppm, clamped to 0..1000.
// The block works on one request at a time. The median search scans the ring
// memory once per sample bit (twice for an even fill); then the serial 39-bit
// divider and the polynomial produce the ppm value. A full ring of 30 holds
// an even count and so takes both searches.
// The result sits in an output register, so the next request is accepted
// as soon as the result is handed to that register, even while the
// receiver stalls; a second result waits in the converter until the
// register frees up. After reset the ring is empty, the first result reports
// a median of zero unless the request stores a sample, and i_req.ready is
// high at once.
// ----------------------------------------------------------------------------
module tds_median_filter_convert_core #(
    parameter int RING_DEPTH  = tds_pkg::RING_DEPTH_DEF,
    parameter int SAMPLE_BITS = tds_pkg::SAMPLE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tds_in_if.sink    i_req,
    tds_out_if.source o_res
);
    import tds_pkg::*;

    logic                       r_busy;
    logic                       r_out_valid;
    logic [MEDIAN_W-1:0]        r_out_median;
    logic [PPM_W-1:0]           r_out_ppm;
    logic [MEDIAN_W-1:0]        r_median;
    logic signed [TEMP_W-1:0]   r_temp;

    t_ring_res                  ring_res;
    logic                       accept;
    logic                       conv_done;
    logic                       conv_take;
    logic [PPM_W-1:0]           conv_ppm;

    // A request is taken only while no earlier request is still in work.
    assign i_req.ready = !r_busy;
    assign accept      = i_req.valid && !r_busy;

    // The converter result moves into the output register when it is free.
    assign conv_take   = conv_done && (!r_out_valid || o_res.ready);

    assign o_res.valid      = r_out_valid;
    assign o_res.median_raw = r_out_median;
    assign o_res.tds_ppm    = r_out_ppm;

    tds_ring #(
        .RING_DEPTH  (RING_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_store  (i_req.sample_valid),
        .i_sample (i_req.adc_sample),
        .o_res    (ring_res)
    );

    tds_conv u_conv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (ring_res.done),
        .i_take   (conv_take),
        .i_median (ring_res.median),
        .i_temp   (r_temp),
        .o_done   (conv_done),
        .o_ppm    (conv_ppm)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
                r_temp <= i_req.water_temp_sixteenths;
            end else if (conv_take) begin
                r_busy <= 1'b0;
            end
            // The median is kept beside the converter while it works.
            if (ring_res.done) begin
                r_median <= ring_res.median;
            end
            if (conv_take) begin
                r_out_valid  <= 1'b1;
                r_out_median <= r_median;
                r_out_ppm    <= conv_ppm;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_busy)
        else $error("request accepted without marking the block busy");

    a_conv_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (conv_done && !conv_take) |=> conv_done)
        else $error("converter result dropped while output register was full");

    a_ppm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        conv_take |=> (r_out_valid && (r_out_ppm <= PPM_MAX)))
        else $error("result not loaded or ppm out of range");
`endif

endmodule
